FILE: rtl/dspt_pkg.sv
package dspt_pkg;

  localparam int MAX_ROWS = 1024;
  localparam int MAX_COLS = 4096;

  // Widths fixed by the item and register fields.
  localparam int ACT_W      = 2;
  localparam int COL_W      = 13;
  localparam int ROWF_W     = 11;
  localparam int ROWIDX_W   = 10;
  localparam int HEIGHT_W   = 11;
  localparam int STRIDE_W   = 13;
  localparam int OFF_W      = 24;
  localparam int CNT_W      = 15;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  // Row store addressing; the walk counter must also hold MAX_ROWS itself.
  localparam int ROW_AW = $clog2(MAX_ROWS);
  localparam int ROW_CW = $clog2(MAX_ROWS + 1);

  // Store word: dirty mark, span start, span end.
  localparam int MEM_W = 1 + 2 * COL_W;

  localparam int PROD_W = ROWIDX_W + STRIDE_W;

  localparam logic [ACT_W-1:0] ACT_INV   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DRAIN = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 1'd1;

  typedef struct packed {
    logic accept;     // latch the item fields
    logic inv_step;   // one step of the invalidate row walk
    logic clr_step;   // clear one row mark
    logic drn_read;   // read the row being drained
    logic drn_fin;    // build the drain result and clean the row
    logic res_zero;   // all-zero result
    logic res_oor;    // drain of a row outside the height
    logic out_load;   // move the result to the output register
  } dspt_cmd_t;

  typedef struct packed {
    logic inv_done;
    logic clr_last;
    logic drn_in_range;
    logic out_free;
  } dspt_stat_t;

endpackage

FILE: rtl/dspt_ctrl.sv
module dspt_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [dspt_pkg::ACT_W-1:0]  in_action,
  output logic                        in_stall,
  input  dspt_pkg::dspt_stat_t        stat,
  output dspt_pkg::dspt_cmd_t         cmd
);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_INV  = 3'd2;
  localparam logic [2:0] S_CLR  = 3'd3;
  localparam logic [2:0] S_DRD  = 3'd4;
  localparam logic [2:0] S_DFIN = 3'd5;
  localparam logic [2:0] S_RES  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (in_action)
            dspt_pkg::ACT_INV:   state_nxt = S_INV;
            dspt_pkg::ACT_DRAIN: state_nxt = S_DRD;
            dspt_pkg::ACT_CLEAR: state_nxt = S_CLR;
            default: begin
              cmd.res_zero = 1'b1;
              state_nxt    = S_RES;
            end
          endcase
        end
      end
      S_INV: begin
        if (stat.inv_done) begin
          cmd.res_zero = 1'b1;
          state_nxt    = S_RES;
        end else begin
          cmd.inv_step = 1'b1;
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          cmd.res_zero = 1'b1;
          state_nxt    = S_RES;
        end
      end
      S_DRD: begin
        if (stat.drn_in_range) begin
          cmd.drn_read = 1'b1;
          state_nxt    = S_DFIN;
        end else begin
          cmd.res_oor = 1'b1;
          state_nxt   = S_RES;
        end
      end
      S_DFIN: begin
        cmd.drn_fin = 1'b1;
        state_nxt   = S_RES;
      end
      S_RES: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/dspt_dp.sv
module dspt_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dspt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dspt_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [dspt_pkg::ACT_W-1:0]          in_action,
  input  logic [dspt_pkg::COL_W-1:0]          in_rect_left,
  input  logic [dspt_pkg::COL_W-1:0]          in_rect_right,
  input  logic [dspt_pkg::ROWF_W-1:0]         in_rect_top,
  input  logic [dspt_pkg::ROWF_W-1:0]         in_rect_bottom,
  input  logic [dspt_pkg::ROWIDX_W-1:0]       in_row_index,
  input  dspt_pkg::dspt_cmd_t                 cmd,
  output dspt_pkg::dspt_stat_t                stat,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [dspt_pkg::ROWIDX_W-1:0]       out_row_number,
  output logic                                out_row_dirty,
  output logic [dspt_pkg::COL_W-1:0]          out_span_start,
  output logic [dspt_pkg::COL_W-1:0]          out_span_end,
  output logic [dspt_pkg::OFF_W-1:0]          out_byte_offset,
  output logic [dspt_pkg::CNT_W-1:0]          out_byte_count
);

  localparam logic [dspt_pkg::COL_W-1:0] COL_MAX = dspt_pkg::COL_W'(dspt_pkg::MAX_COLS);
  localparam logic [dspt_pkg::HEIGHT_W-1:0] ROWS_MAX =
    dspt_pkg::HEIGHT_W'(dspt_pkg::MAX_ROWS);
  localparam logic [dspt_pkg::ROW_CW-1:0] LAST_ROW = dspt_pkg::ROW_CW'(dspt_pkg::MAX_ROWS - 1);

  // Configuration registers.
  logic [dspt_pkg::HEIGHT_W-1:0] height_r;
  logic [dspt_pkg::STRIDE_W-1:0] stride_r;

  // Latched item.
  logic [dspt_pkg::COL_W-1:0]    left_r;
  logic [dspt_pkg::COL_W-1:0]    right_r;
  logic [dspt_pkg::ROWF_W-1:0]   bottom_r;
  logic [dspt_pkg::ROWIDX_W-1:0] row_r;

  // Row walk.
  logic [dspt_pkg::ROW_CW-1:0]   rcnt_r;
  logic                          pend_r;
  logic [dspt_pkg::ROW_AW-1:0]   pend_row_r;

  // Row store.
  logic [dspt_pkg::MEM_W-1:0]    mem [dspt_pkg::MAX_ROWS];
  logic [dspt_pkg::MEM_W-1:0]    rd_data_r;
  logic                          rd_en;
  logic [dspt_pkg::ROW_AW-1:0]   rd_addr;
  logic                          wr_en;
  logic [dspt_pkg::ROW_AW-1:0]   wr_addr;
  logic [dspt_pkg::MEM_W-1:0]    wr_data;

  logic [dspt_pkg::PROD_W-1:0]   prod_r;

  // Result held until the output register is free.
  logic [dspt_pkg::ROWIDX_W-1:0] res_row_r;
  logic                          res_dirty_r;
  logic [dspt_pkg::COL_W-1:0]    res_start_r;
  logic [dspt_pkg::COL_W-1:0]    res_end_r;
  logic [dspt_pkg::OFF_W-1:0]    res_off_r;
  logic [dspt_pkg::CNT_W-1:0]    res_cnt_r;

  logic                          out_valid_r;
  logic [dspt_pkg::ROWIDX_W-1:0] out_row_r;
  logic                          out_dirty_r;
  logic [dspt_pkg::COL_W-1:0]    out_start_r;
  logic [dspt_pkg::COL_W-1:0]    out_end_r;
  logic [dspt_pkg::OFF_W-1:0]    out_off_r;
  logic [dspt_pkg::CNT_W-1:0]    out_cnt_r;

  logic [dspt_pkg::HEIGHT_W-1:0] rows_used;
  logic [dspt_pkg::ROWF_W-1:0]   bot;
  logic                          rect_empty;
  logic                          issue;
  logic                          rd_dirty;
  logic [dspt_pkg::COL_W-1:0]    rd_start;
  logic [dspt_pkg::COL_W-1:0]    rd_end;
  logic [dspt_pkg::COL_W-1:0]    mrg_start;
  logic [dspt_pkg::COL_W-1:0]    mrg_end;
  logic [dspt_pkg::OFF_W-1:0]    off_sum;
  logic [dspt_pkg::OFF_W-1:0]    drn_off;
  logic [dspt_pkg::CNT_W-1:0]    drn_cnt;

  always_comb begin
    rows_used  = (height_r > ROWS_MAX) ? ROWS_MAX : height_r;
    bot        = (bottom_r > rows_used) ? rows_used : bottom_r;
    rect_empty = (left_r >= right_r);
    issue      = !rect_empty && (rcnt_r < bot);

    rd_dirty = rd_data_r[dspt_pkg::MEM_W-1];
    rd_start = rd_data_r[2*dspt_pkg::COL_W-1:dspt_pkg::COL_W];
    rd_end   = rd_data_r[dspt_pkg::COL_W-1:0];

    // A clean row takes the rectangle's columns; a dirty row widens.
    if (rd_dirty) begin
      mrg_start = (left_r < rd_start) ? left_r : rd_start;
      mrg_end   = (right_r > rd_end) ? right_r : rd_end;
    end else begin
      mrg_start = left_r;
      mrg_end   = right_r;
    end

    // Byte offset is (row * stride + start) * 4, saturated to the field.
    off_sum = dspt_pkg::OFF_W'(prod_r) + dspt_pkg::OFF_W'(rd_start);
    if (off_sum[dspt_pkg::OFF_W-1:dspt_pkg::OFF_W-2] != 2'b00) begin
      drn_off = '1;
    end else begin
      drn_off = {off_sum[dspt_pkg::OFF_W-3:0], 2'b00};
    end
    if (rd_end > rd_start) begin
      drn_cnt = {dspt_pkg::CNT_W'(rd_end - rd_start)} << 2;
    end else begin
      drn_cnt = '0;
    end

    rd_en   = 1'b0;
    rd_addr = rcnt_r[dspt_pkg::ROW_AW-1:0];
    if (cmd.inv_step && issue) begin
      rd_en = 1'b1;
    end else if (cmd.drn_read) begin
      rd_en   = 1'b1;
      rd_addr = row_r;
    end

    wr_en   = 1'b0;
    wr_addr = rcnt_r[dspt_pkg::ROW_AW-1:0];
    wr_data = '0;
    if (cmd.clr_step) begin
      wr_en = 1'b1;
    end else if (cmd.inv_step && pend_r) begin
      wr_en   = 1'b1;
      wr_addr = pend_row_r;
      wr_data = {1'b1, mrg_start, mrg_end};
    end else if (cmd.drn_fin) begin
      wr_en   = 1'b1;
      wr_addr = row_r;
      wr_data = {1'b0, rd_start, rd_end};
    end

    stat.inv_done     = !issue && !pend_r;
    stat.clr_last     = (rcnt_r == LAST_ROW);
    stat.drn_in_range = ({1'b0, row_r} < rows_used);
    stat.out_free     = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= ROWS_MAX;
      stride_r <= dspt_pkg::STRIDE_W'(4096);
    end else if (cfg_we) begin
      unique case (cfg_index)
        dspt_pkg::CFG_HEIGHT: height_r <= cfg_wdata[dspt_pkg::HEIGHT_W-1:0];
        dspt_pkg::CFG_STRIDE: stride_r <= cfg_wdata[dspt_pkg::STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rcnt_r <= '0;
      pend_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        rcnt_r <= (in_action == dspt_pkg::ACT_INV) ? in_rect_top : '0;
      end else if (cmd.clr_step || (cmd.inv_step && issue)) begin
        rcnt_r <= rcnt_r + 1'b1;
      end
      if (cmd.inv_step) begin
        pend_r <= issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.inv_step) begin
      pend_row_r <= rcnt_r[dspt_pkg::ROW_AW-1:0];
    end
    if (cmd.accept) begin
      left_r   <= (in_rect_left > COL_MAX) ? COL_MAX : in_rect_left;
      right_r  <= (in_rect_right > COL_MAX) ? COL_MAX : in_rect_right;
      bottom_r <= in_rect_bottom;
      row_r    <= in_row_index;
    end
    prod_r <= dspt_pkg::PROD_W'(row_r) * dspt_pkg::PROD_W'(stride_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.res_zero) begin
      res_row_r   <= '0;
      res_dirty_r <= 1'b0;
      res_start_r <= '0;
      res_end_r   <= '0;
      res_off_r   <= '0;
      res_cnt_r   <= '0;
    end else if (cmd.res_oor || (cmd.drn_fin && !rd_dirty)) begin
      res_row_r   <= row_r;
      res_dirty_r <= 1'b0;
      res_start_r <= '0;
      res_end_r   <= '0;
      res_off_r   <= '0;
      res_cnt_r   <= '0;
    end else if (cmd.drn_fin) begin
      res_row_r   <= row_r;
      res_dirty_r <= 1'b1;
      res_start_r <= rd_start;
      res_end_r   <= rd_end;
      res_off_r   <= drn_off;
      res_cnt_r   <= drn_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_row_r   <= res_row_r;
      out_dirty_r <= res_dirty_r;
      out_start_r <= res_start_r;
      out_end_r   <= res_end_r;
      out_off_r   <= res_off_r;
      out_cnt_r   <= res_cnt_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_row_number  = out_row_r;
  assign out_row_dirty   = out_dirty_r;
  assign out_span_start  = out_start_r;
  assign out_span_end    = out_end_r;
  assign out_byte_offset = out_off_r;
  assign out_byte_count  = out_cnt_r;

endmodule

FILE: rtl/dirty_scanline_span_tracker_core.sv
// Each action runs its own steps before its result: invalidate visits the clipped rows,
// drain reads the row and then builds the result (it skips the read outside the height),
// clear visits all MAX_ROWS rows, and the spare action goes straight to a zero result.
// One item is in work at a time. A finished result sits in an output register, so a new
// item is taken while it waits. After reset (rst_n synchronous, active low) a clearing
// pass marks all rows clean, with in_stall high; configuration writes are taken throughout.
module dirty_scanline_span_tracker_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dspt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dspt_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [dspt_pkg::ACT_W-1:0]          in_action,
  input  logic [dspt_pkg::COL_W-1:0]          in_rect_left,
  input  logic [dspt_pkg::COL_W-1:0]          in_rect_right,
  input  logic [dspt_pkg::ROWF_W-1:0]         in_rect_top,
  input  logic [dspt_pkg::ROWF_W-1:0]         in_rect_bottom,
  input  logic [dspt_pkg::ROWIDX_W-1:0]       in_row_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [dspt_pkg::ROWIDX_W-1:0]       out_row_number,
  output logic                                out_row_dirty,
  output logic [dspt_pkg::COL_W-1:0]          out_span_start,
  output logic [dspt_pkg::COL_W-1:0]          out_span_end,
  output logic [dspt_pkg::OFF_W-1:0]          out_byte_offset,
  output logic [dspt_pkg::CNT_W-1:0]          out_byte_count
);

  dspt_pkg::dspt_cmd_t  cmd;
  dspt_pkg::dspt_stat_t stat;

  dspt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  dspt_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_action       (in_action),
    .in_rect_left    (in_rect_left),
    .in_rect_right   (in_rect_right),
    .in_rect_top     (in_rect_top),
    .in_rect_bottom  (in_rect_bottom),
    .in_row_index    (in_row_index),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row_number  (out_row_number),
    .out_row_dirty   (out_row_dirty),
    .out_span_start  (out_span_start),
    .out_span_end    (out_span_end),
    .out_byte_offset (out_byte_offset),
    .out_byte_count  (out_byte_count)
  );

endmodule

FILE: test/dirty_scanline_span_tracker_core_tb.sv
module dirty_scanline_span_tracker_core_tb;
  import dspt_pkg::*;

  // The fourth action code does nothing but still returns an all-zero result.
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
  localparam logic [OFF_W-1:0] OFFSET_SAT = {OFF_W{1'b1}};
  localparam int MAX_REPORTS = 50;

  typedef struct packed {
    logic [ACT_W-1:0]    action;
    logic [COL_W-1:0]    left;
    logic [COL_W-1:0]    right;
    logic [ROWF_W-1:0]   top;
    logic [ROWF_W-1:0]   bottom;
    logic [ROWIDX_W-1:0] row;
  } span_req_t;

  typedef struct packed {
    logic [ROWIDX_W-1:0] row_num;
    logic                dirty;
    logic [COL_W-1:0]    span_lo;
    logic [COL_W-1:0]    span_hi;
    logic [OFF_W-1:0]    byte_off;
    logic [CNT_W-1:0]    byte_cnt;
  } span_rpt_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ACT_W-1:0] in_action = '0;
  logic [COL_W-1:0] in_rect_left = '0;
  logic [COL_W-1:0] in_rect_right = '0;
  logic [ROWF_W-1:0] in_rect_top = '0;
  logic [ROWF_W-1:0] in_rect_bottom = '0;
  logic [ROWIDX_W-1:0] in_row_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ROWIDX_W-1:0] out_row_number;
  logic out_row_dirty;
  logic [COL_W-1:0] out_span_start;
  logic [COL_W-1:0] out_span_end;
  logic [OFF_W-1:0] out_byte_offset;
  logic [CNT_W-1:0] out_byte_count;

  dirty_scanline_span_tracker_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_rect_left   (in_rect_left),
    .in_rect_right  (in_rect_right),
    .in_rect_top    (in_rect_top),
    .in_rect_bottom (in_rect_bottom),
    .in_row_index   (in_row_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_row_number (out_row_number),
    .out_row_dirty  (out_row_dirty),
    .out_span_start (out_span_start),
    .out_span_end   (out_span_end),
    .out_byte_offset(out_byte_offset),
    .out_byte_count (out_byte_count)
  );

  always #1 clk = ~clk;

  // Shadow copy of the row store and registers.
  logic                row_marked [MAX_ROWS];
  logic [COL_W-1:0]    row_span_lo [MAX_ROWS];
  logic [COL_W-1:0]    row_span_hi [MAX_ROWS];
  logic [HEIGHT_W-1:0] shadow_height = 11'd1024;
  logic [STRIDE_W-1:0] shadow_stride = 13'd4096;

  span_req_t pending_reqs[$];
  span_rpt_t expected_rpts[$];
  span_req_t cur_req = '0;
  span_rpt_t want_rpt;
  logic req_taken = 1'b0;
  int reqs_in_flight = 0;
  int rpts_checked = 0;
  int mismatches = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;

  function automatic bit chance(int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic span_rpt_t apply_span_item(span_req_t r);
    span_rpt_t rpt;
    int unsigned rows_used, lo, hi, bot, k;
    longint unsigned off;
    rpt = '0;
    rows_used = (shadow_height > MAX_ROWS) ? MAX_ROWS : shadow_height;
    lo = (r.left > MAX_COLS) ? MAX_COLS : r.left;
    hi = (r.right > MAX_COLS) ? MAX_COLS : r.right;
    case (r.action)
      ACT_INV: begin
        bot = (r.bottom > rows_used) ? rows_used : r.bottom;
        if (lo < hi) begin
          for (k = r.top; k < bot; k++) begin
            if (row_marked[k]) begin
              if (lo < row_span_lo[k]) row_span_lo[k] = COL_W'(lo);
              if (hi > row_span_hi[k]) row_span_hi[k] = COL_W'(hi);
            end else begin
              row_marked[k] = 1'b1;
              row_span_lo[k] = COL_W'(lo);
              row_span_hi[k] = COL_W'(hi);
            end
          end
        end
      end
      ACT_DRAIN: begin
        rpt.row_num = r.row;
        if (r.row < rows_used && row_marked[r.row]) begin
          off = (longint'(r.row) * longint'(shadow_stride) + row_span_lo[r.row]) * 4;
          rpt.dirty = 1'b1;
          rpt.span_lo = row_span_lo[r.row];
          rpt.span_hi = row_span_hi[r.row];
          rpt.byte_off = (off > OFFSET_SAT) ? OFFSET_SAT : off[OFF_W-1:0];
          rpt.byte_cnt = (row_span_hi[r.row] > row_span_lo[r.row]) ?
                         CNT_W'((row_span_hi[r.row] - row_span_lo[r.row]) * 4) : '0;
          row_marked[r.row] = 1'b0;
        end
      end
      ACT_CLEAR: begin
        for (k = 0; k < MAX_ROWS; k++) row_marked[k] = 1'b0;
      end
      default: ;
    endcase
    return rpt;
  endfunction

  function automatic span_req_t make_req(logic [ACT_W-1:0] action, int left, int right,
                                         int top, int bottom, int row);
    span_req_t r;
    r.action = action;
    r.left = COL_W'(left);
    r.right = COL_W'(right);
    r.top = ROWF_W'(top);
    r.bottom = ROWF_W'(bottom);
    r.row = ROWIDX_W'(row);
    return r;
  endfunction

  // Mostly well-formed invalidates and drains around a window of 16 rows, so that
  // drains find dirty rows; the rest is full-range noise, clears and the spare code.
  function automatic span_req_t random_req(int unsigned focus);
    span_req_t r;
    int unsigned pick;
    r.left = COL_W'($urandom_range(8191));
    r.right = COL_W'($urandom_range(8191));
    r.top = ROWF_W'($urandom_range(2047));
    r.bottom = ROWF_W'($urandom_range(2047));
    r.row = ROWIDX_W'($urandom_range(1023));
    pick = $urandom_range(99);
    if (pick < 46) begin
      r.action = ACT_INV;
      if ($urandom_range(9) != 0) begin
        r.top = ROWF_W'(focus + $urandom_range(15));
        r.bottom = ROWF_W'(r.top + $urandom_range(6, 1));
        r.left = COL_W'($urandom_range(4095));
        r.right = COL_W'(r.left + $urandom_range(4096 - r.left, 1));
      end
    end else if (pick < 94) begin
      r.action = ACT_DRAIN;
      if ($urandom_range(6) != 0) r.row = ROWIDX_W'(focus + $urandom_range(15));
    end else if (pick < 97) begin
      r.action = ACT_CLEAR;
    end else begin
      r.action = ACT_SPARE;
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < MAX_REPORTS)
      $display("MISMATCH at %0t, result %0d: %s", $time, rpts_checked, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  task automatic queue_item(span_req_t r);
    pending_reqs.push_back(r);
    reqs_in_flight++;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (reqs_in_flight != 0 || expected_rpts.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    if (idx == CFG_HEIGHT) shadow_height = HEIGHT_W'(val);
    else shadow_stride = STRIDE_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_geometry(int unsigned height, int unsigned stride);
    write_reg(CFG_HEIGHT, height);
    write_reg(CFG_STRIDE, stride);
  endtask

  task automatic run_random(int count, int unsigned focus);
    repeat (count) queue_item(random_req(focus));
    wait_idle();
  endtask

  // Driver: a new item goes out once the current one has been taken.
  always @(negedge clk) begin
    if (!in_valid || req_taken) begin
      if (pending_reqs.size() != 0 && !chance(send_gap_pct)) begin
        cur_req = pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_action <= cur_req.action;
        in_rect_left <= cur_req.left;
        in_rect_right <= cur_req.right;
        in_rect_top <= cur_req.top;
        in_rect_bottom <= cur_req.bottom;
        in_row_index <= cur_req.row;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) out_stall <= chance(recv_stall_pct);

  always @(posedge clk) begin
    req_taken <= in_valid && !in_stall;
    if (in_valid && !in_stall) begin
      expected_rpts.push_back(apply_span_item(cur_req));
      reqs_in_flight--;
    end
  end

  // Monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rpts.size() == 0) begin
        report_mismatch("result item with no item outstanding");
      end else begin
        want_rpt = expected_rpts.pop_front();
        check_field("row_number", out_row_number, want_rpt.row_num);
        check_field("row_dirty", out_row_dirty, want_rpt.dirty);
        check_field("span_start", out_span_start, want_rpt.span_lo);
        check_field("span_end", out_span_end, want_rpt.span_hi);
        check_field("byte_offset", out_byte_offset, want_rpt.byte_off);
        check_field("byte_count", out_byte_count, want_rpt.byte_cnt);
      end
      rpts_checked++;
    end
  end

  initial begin
    int k;
    for (k = 0; k < MAX_ROWS; k++) row_marked[k] = 1'b0;
    send_gap_pct = 23;
    recv_stall_pct = 53;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Height beyond the store, widest stride: full-frame invalidate with column
    // clipping, saturated offset on the last row, and a rectangle clipped to empty.
    set_geometry(2047, 8191);
    queue_item(make_req(ACT_INV, 0, 8191, 0, 2047, 0));
    queue_item(make_req(ACT_DRAIN, 0, 0, 0, 0, 1023));
    queue_item(make_req(ACT_DRAIN, 8191, 8191, 2047, 2047, 0));
    queue_item(make_req(ACT_INV, 8191, 8191, 0, 2, 0));
    queue_item(make_req(ACT_DRAIN, 0, 0, 0, 0, 1));
    queue_item(make_req(ACT_CLEAR, 0, 0, 0, 0, 0));
    queue_item(make_req(ACT_DRAIN, 0, 0, 0, 0, 2));
    wait_idle();

    // Clean rows take the span, dirty rows widen it; empty rectangles.
    set_geometry(1024, 4096);
    queue_item(make_req(ACT_INV, 100, 200, 5, 8, 0));
    queue_item(make_req(ACT_INV, 50, 150, 6, 9, 0));
    queue_item(make_req(ACT_INV, 120, 300, 5, 7, 0));
    queue_item(make_req(ACT_INV, 300, 300, 10, 12, 0));
    queue_item(make_req(ACT_INV, 500, 400, 10, 12, 0));
    queue_item(make_req(ACT_INV, 0, 10, 20, 20, 0));
    queue_item(make_req(ACT_INV, 0, 10, 31, 25, 0));
    queue_item(make_req(ACT_INV, 4095, 4096, 30, 31, 0));
    queue_item(make_req(ACT_SPARE, 8191, 8191, 2047, 2047, 1023));
    queue_item(make_req(ACT_DRAIN, 0, 0, 0, 0, 5));
    queue_item(make_req(ACT_DRAIN, 0, 0, 0, 0, 6));
    queue_item(make_req(ACT_DRAIN, 0, 0, 0, 0, 7));
    queue_item(make_req(ACT_DRAIN, 0, 0, 0, 0, 8));
    queue_item(make_req(ACT_DRAIN, 0, 0, 0, 0, 10));
    wait_idle();

    // Lowered height: row 30 keeps its mark but drains as out of range.
    set_geometry(8, 1);
    queue_item(make_req(ACT_DRAIN, 0, 0, 0, 0, 30));
    queue_item(make_req(ACT_INV, 0, 1, 0, 2047, 0));
    wait_idle();

    set_geometry(1024, 4096);
    queue_item(make_req(ACT_DRAIN, 0, 0, 0, 0, 30));
    queue_item(make_req(ACT_DRAIN, 0, 0, 0, 0, 9));
    wait_idle();

    run_random(100, $urandom_range(1008));
    set_geometry(1, 1);
    run_random(60, 0);

    send_gap_pct = 53;
    recv_stall_pct = 23;
    set_geometry(2047, 8191);
    run_random(110, 1008);
    set_geometry(0, 0);
    run_random(40, 0);

    send_gap_pct = 0;
    recv_stall_pct = 0;
    set_geometry(24, $urandom_range(4096, 1));
    run_random(120, 0);
    set_geometry(1024, 4096);
    run_random(120, $urandom_range(1008));

    repeat (40) @(negedge clk);
    if (mismatches == 0 && expected_rpts.size() == 0)
      $display("dirty_scanline_span_tracker_core test passed");
    else
      $display("dirty_scanline_span_tracker_core test failed");
    $finish;
  end

  initial begin
    #5000000;
    $display("dirty_scanline_span_tracker_core test failed");
    $finish;
  end

endmodule
